@@ src/srfc_pkg.sv @@
// Shared types and constants of the sensor response frame checker.
// Used by the channel interfaces and by every module of the block; depends on nothing.
package srfc_pkg;

   localparam int FRAME_LENGTH = 11;
   localparam int INDEX_WIDTH = 4;
   localparam int SUM_LAST = 8;
   localparam int CHECK_POS = 9;
   localparam int END_POS = 10;

   localparam logic [7:0] START_MARK = 8'hAA;
   localparam logic [7:0] END_MARK = 8'h55;
   localparam logic [15:0] TIMEOUT_RESET = 16'd100;
   localparam logic [15:0] TICKS_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_RX_BYTE = 2'd0,
      OP_TICK = 2'd1,
      OP_REQUEST = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_CHECKSUM = 2'd1,
      STATUS_MARKS = 2'd2
   } status_type;

   typedef logic [FRAME_LENGTH-1:0][7:0] frame_type;

   typedef struct packed {
      frame_type frame;
      logic marks_ok;
      logic power;
   } job_type;

   typedef struct packed {
      logic push_valid;
      logic push_ready;
   } queue_ctl_type;

endpackage

@@ src/srfc_req_if.sv @@
// Request channel interface: operation and received byte with valid/ready.
// Depends on srfc_pkg for nothing but the shared naming; carries plain field widths.
interface srfc_req_if import srfc_pkg::*; ();
   logic valid;
   logic ready;
   logic [1:0] operation;
   logic [7:0] rx_byte;

   modport source (output valid, output operation, output rx_byte, input ready);
   modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

@@ src/srfc_rsp_if.sv @@
// Response channel interface: one evaluated frame per beat with valid/ready.
// Depends on srfc_pkg.
interface srfc_rsp_if import srfc_pkg::*; ();
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [15:0] first_value;
   logic [15:0] second_value;
   logic [7:0] temperature;
   logic [7:0] computed_checksum;
   logic sensor_power;

   modport source (output valid, output status, output first_value, output second_value,
                   output temperature, output computed_checksum, output sensor_power,
                   input ready);
   modport sink (input valid, input status, input first_value, input second_value,
                 input temperature, input computed_checksum, input sensor_power,
                 output ready);
endinterface

@@ src/srfc_csr_if.sv @@
// Configuration write channel interface: timeout register write data with valid/ready.
// Depends on srfc_pkg.
interface srfc_csr_if import srfc_pkg::*; ();
   logic valid;
   logic ready;
   logic [15:0] wr_data;

   modport source (output valid, output wr_data, input ready);
   modport sink (input valid, input wr_data, output ready);
endinterface

@@ src/sensor_response_frame_checker_core.sv @@
// Top level of the sensor response frame checker: front end, frame queue and back end.
// Depends on srfc_pkg, the three channel interfaces, srfc_front, srfc_queue and srfc_back.

// The block takes one request beat per cycle (received byte, tick or new request) and
// returns one response beat for each frame that ends on an end mark, a full buffer or a
// timeout. The front end writes a finished frame into the queue, and the back end
// sums bytes 0 to 8 in an adder tree and registers the result. The request side
// stalls only when the queue of QUEUE_DEPTH finished frames is full because the
// response side is not taking beats. The timeout register is written through the
// configuration channel, which never stalls, and no clearing pass is needed after
// reset.
module sensor_response_frame_checker_core import srfc_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input logic clock,
   input logic reset,
   srfc_req_if.sink req_bus,
   srfc_rsp_if.source rsp_bus,
   srfc_csr_if.sink csr_bus
);

   queue_ctl_type push_ctl;
   logic push_ready;
   job_type push_job;
   logic pop_valid;
   logic pop_ready;
   job_type pop_job;

   srfc_front u_front (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .csr_bus(csr_bus),
      .push_ctl_out(push_ctl),
      .push_ready(push_ready),
      .push_job(push_job)
   );

   srfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_ctl.push_valid),
      .push_ready(push_ready),
      .push_job(push_job),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_job(pop_job)
   );

   srfc_back u_back (
      .clock(clock),
      .reset(reset),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_job(pop_job),
      .rsp_bus(rsp_bus)
   );

   assert property (@(posedge clock) disable iff (reset)
      push_ctl.push_valid |-> (push_ctl.push_ready && req_bus.valid))
      else $error("Frame pushed without an accepted request beat.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status != STATUS_OK)) |->
      ((rsp_bus.first_value == '0) && (rsp_bus.second_value == '0)
       && (rsp_bus.temperature == '0)))
      else $error("Values reported for a frame that failed its checks.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status == STATUS_MARKS)) |-> !rsp_bus.sensor_power)
      else $error("Sensor power kept on after a frame without marks.");

   assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> rsp_bus.valid)
      else $error("Frame taken from the queue but no response beat followed.");

endmodule

@@ src/srfc_front.sv @@
// Front end: accepts request beats, collects the frame, counts ticks and detects frame end.
// Depends on srfc_pkg, srfc_req_if and srfc_csr_if; pushes finished frames to srfc_queue.
module srfc_front import srfc_pkg::*; (
   input logic clock,
   input logic reset,
   srfc_req_if.sink req_bus,
   srfc_csr_if.sink csr_bus,
   output queue_ctl_type push_ctl_out,
   input logic push_ready,
   output job_type push_job
);

   frame_type frame_ff, frame_in;
   logic [INDEX_WIDTH-1:0] index_ff, index_in;
   logic awaiting_ff, awaiting_in;
   logic [15:0] ticks_ff, ticks_in;
   logic power_ff, power_in;
   logic [15:0] timeout_ff;

   logic accept;
   logic finish;
   logic marks_ok;
   logic [INDEX_WIDTH-1:0] index_eff;
   logic [INDEX_WIDTH-1:0] index_next;

   assign req_bus.ready = push_ready;
   assign csr_bus.ready = 1'b1;
   assign accept = req_bus.valid && push_ready;

   always_comb begin
      frame_in = frame_ff;
      index_in = index_ff;
      awaiting_in = awaiting_ff;
      ticks_in = ticks_ff;
      power_in = power_ff;
      finish = 1'b0;
      index_eff = (req_bus.rx_byte == START_MARK) ? '0 : index_ff;
      index_next = index_eff + 1'b1;
      if (accept) begin
         case (op_type'(req_bus.operation))
            OP_REQUEST: begin
               frame_in = '0;
               index_in = '0;
               ticks_in = '0;
               awaiting_in = 1'b1;
               power_in = 1'b1;
            end
            OP_RX_BYTE: begin
               if (awaiting_ff) begin
                  for (int k = 0; k < FRAME_LENGTH; k++) begin
                     if (index_eff == INDEX_WIDTH'(k)) begin
                        frame_in[k] = req_bus.rx_byte;
                     end
                  end
                  index_in = index_next;
                  finish = (index_next >= INDEX_WIDTH'(FRAME_LENGTH))
                           || (req_bus.rx_byte == END_MARK);
               end
            end
            OP_TICK: begin
               if (awaiting_ff) begin
                  if (ticks_ff != TICKS_MAX) begin
                     ticks_in = ticks_ff + 16'd1;
                  end
                  finish = ticks_in > timeout_ff;
               end
            end
            default: begin
            end
         endcase
      end
      marks_ok = (frame_in[0] == START_MARK) && (frame_in[END_POS] == END_MARK);
      if (finish) begin
         awaiting_in = 1'b0;
         if (!marks_ok) begin
            power_in = 1'b0;
         end
      end
   end

   assign push_ctl_out.push_valid = finish;
   assign push_ctl_out.push_ready = push_ready;
   assign push_job.frame = frame_in;
   assign push_job.marks_ok = marks_ok;
   assign push_job.power = power_ff;

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      if (reset) begin
         awaiting_ff <= 1'b0;
         power_ff <= 1'b1;
         timeout_ff <= TIMEOUT_RESET;
         index_ff <= '0;
         ticks_ff <= '0;
      end else begin
         awaiting_ff <= awaiting_in;
         power_ff <= power_in;
         index_ff <= index_in;
         ticks_ff <= ticks_in;
         if (csr_bus.valid) begin
            timeout_ff <= csr_bus.wr_data;
         end
      end
   end

endmodule

@@ src/srfc_queue.sv @@
// Short first-in first-out queue of finished frames between the front and back ends.
// Depends on srfc_pkg for the frame record type.
module srfc_queue import srfc_pkg::*; #(
   parameter int DEPTH = 2
) (
   input logic clock,
   input logic reset,
   input logic push_valid,
   output logic push_ready,
   input job_type push_job,
   output logic pop_valid,
   input logic pop_ready,
   output job_type pop_job
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   job_type entries_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = count_ff != COUNT_WIDTH'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_job = entries_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ src/srfc_back.sv @@
// Back end: computes the checksum and status of a queued frame into the response register.
// Depends on srfc_pkg and srfc_rsp_if; pops frames from srfc_queue.
module srfc_back import srfc_pkg::*; (
   input logic clock,
   input logic reset,
   input logic pop_valid,
   output logic pop_ready,
   input job_type pop_job,
   srfc_rsp_if.source rsp_bus
);

   logic valid_ff;
   logic [1:0] status_ff;
   logic [15:0] first_ff, second_ff;
   logic [7:0] temp_ff, check_ff;
   logic power_ff;

   logic [7:0] sum01, sum23, sum45, sum67, sum03, sum47, sum_all;
   logic [7:0] check;
   status_type status;
   logic take;

   assign sum01 = pop_job.frame[0] + pop_job.frame[1];
   assign sum23 = pop_job.frame[2] + pop_job.frame[3];
   assign sum45 = pop_job.frame[4] + pop_job.frame[5];
   assign sum67 = pop_job.frame[6] + pop_job.frame[7];
   assign sum03 = sum01 + sum23;
   assign sum47 = sum45 + sum67;
   assign sum_all = sum03 + sum47 + pop_job.frame[SUM_LAST];
   assign check = 8'd0 - sum_all;

   always_comb begin
      if (!pop_job.marks_ok) begin
         status = STATUS_MARKS;
      end else if (check != pop_job.frame[CHECK_POS]) begin
         status = STATUS_CHECKSUM;
      end else begin
         status = STATUS_OK;
      end
   end

   assign pop_ready = !valid_ff || rsp_bus.ready;
   assign take = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (take) begin
         status_ff <= status;
         check_ff <= check;
         power_ff <= pop_job.power && pop_job.marks_ok;
         if (status == STATUS_OK) begin
            first_ff <= {pop_job.frame[4], pop_job.frame[5]};
            second_ff <= {pop_job.frame[6], pop_job.frame[7]};
            temp_ff <= pop_job.frame[SUM_LAST];
         end else begin
            first_ff <= '0;
            second_ff <= '0;
            temp_ff <= '0;
         end
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop_ready) begin
         valid_ff <= pop_valid;
      end
   end

   assign rsp_bus.valid = valid_ff;
   assign rsp_bus.status = status_ff;
   assign rsp_bus.first_value = first_ff;
   assign rsp_bus.second_value = second_ff;
   assign rsp_bus.temperature = temp_ff;
   assign rsp_bus.computed_checksum = check_ff;
   assign rsp_bus.sensor_power = power_ff;

endmodule
